/* rtl/can_bts_pkg.sv */
// Shared types, field widths and constants for the CAN bit timing search unit.
// No dependencies; every other file of the block except can_bts_ram imports this package.
package can_bts_pkg;

    // Fixed field widths of the configuration, input and result items.
    localparam int OSC_W       = 28;
    localparam int RATE_W      = 10;
    localparam int SPT_W       = 10;
    localparam int PRESC_OUT_W = 6;
    localparam int SEG1_OUT_W  = 5;
    localparam int SEG2_OUT_W  = 4;
    localparam int JW_W        = 2;
    localparam int SP_W        = 14;
    localparam int ERR_W       = 14;

    // Stream widths: input padded to 16 bits, results padded to 48 bits.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;
    localparam int M_PAD_W   = M_TDATA_W - (PRESC_OUT_W + SEG1_OUT_W + SEG2_OUT_W + JW_W
                                            + SP_W + ERR_W + 1);

    // Arithmetic constants.
    localparam int unsigned KILO      = 1000;
    localparam int unsigned SP_SCALE  = 10000;
    localparam int unsigned SCALE_W   = 14;
    localparam int unsigned ERR_MAX   = 16383;
    localparam int unsigned JW_MAX    = 3;
    localparam int          RATE_K_W  = 20;

    // Parameter defaults and the upper limit of the result count.
    localparam int DEF_MAX_PRESCALER = 32;
    localparam int DEF_MAX_SEG1      = 16;
    localparam int DEF_MAX_SEG2      = 8;
    localparam int DEF_MAX_MATCHES   = 64;
    localparam int MATCHES_LIMIT     = 64;
    localparam int CNT_W             = $clog2(MATCHES_LIMIT + 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OSC_HZ    = 2'd0,
        CFG_SP_TARGET = 2'd1,
        CFG_SP_TOL    = 2'd2
    } cfg_index_t;

    // Configuration register set as seen by the search and the emitter.
    typedef struct packed {
        logic [OSC_W-1:0] osc_hz;
        logic [SPT_W-1:0] sp_target;
        logic [SPT_W-1:0] sp_tol;
    } cfg_t;

    // One finished search, handed from the front to the back.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             truncated;
    } desc_t;

    // Two result banks, so the queue holds at most two searches.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RUN,
        F_DRAIN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_DIV_SP,
        B_DIV_ERR,
        B_SEND
    } back_state_t;

endpackage

/* rtl/can_bit_timing_search_unit.sv */
// CAN bit timing search unit, top level. Depends on can_bts_pkg, can_bts_ram,
// can_bts_queue, can_bts_search and can_bts_emit.
//
// An item on the s_axis channel carries a target bit rate in kbit/s. For it the
// unit tries every prescaler, segment one and segment two setting in nested
// order and returns one m_axis item per matching setting, in search order, with
// tlast on the final one. If nothing matches, a single item with tuser 0 and
// tlast 1 is returned. Matches beyond MAX_MATCHES are dropped and every item of
// that request has the truncated bit set.
// The search tests one candidate per cycle and takes no new input item until it
// has handed the finished search to the queue, returned to idle and found the
// queue not full. For each stored match the emitter reads the setting, works
// out its sample point and, unless the target sample point is zero, its
// relative error with its bit-serial divider, and then sends the item. Two
// result banks let the next search run while the previous results are emitted.
// The cfg channel is always ready; write it only while the unit is idle.
// Reset loads the register defaults and empties the queue.
// A stalled m_axis receiver holds the output register; the emitter, then the
// search, wait behind it without losing an item.
module can_bit_timing_search_unit #(
    parameter int MAX_PRESCALER = can_bts_pkg::DEF_MAX_PRESCALER,
    parameter int MAX_SEG1      = can_bts_pkg::DEF_MAX_SEG1,
    parameter int MAX_SEG2      = can_bts_pkg::DEF_MAX_SEG2,
    parameter int MAX_MATCHES   = can_bts_pkg::DEF_MAX_MATCHES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input item: rate_kbps [9:0], zero padding [15:10].
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [can_bts_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Result item: prescaler [5:0], seg1 [10:6], seg2 [14:11], jump_width [16:15],
    // sample_point [30:17], sample_error [44:31], truncated [45], padding [47:46].
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [can_bts_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Result flag: found [0].
    output logic [can_bts_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                                 m_axis_tlast,
    // Configuration writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [can_bts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [can_bts_pkg::OSC_W-1:0]        cfg_data
);

    import can_bts_pkg::*;

    localparam int PW        = $clog2(MAX_PRESCALER + 1);
    localparam int S1W       = $clog2(MAX_SEG1 + 1);
    localparam int S2W       = $clog2(MAX_SEG2 + 1);
    localparam int IDX_W     = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
    localparam int RAM_W     = PW + S1W + S2W;
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

    logic [OSC_W-1:0] osc_reg;
    logic [SPT_W-1:0] tgt_reg;
    logic [SPT_W-1:0] tol_reg;
    cfg_t             cfg;

    logic             q_full;
    logic             push;
    desc_t            push_desc;
    logic             pop;
    logic             head_valid;
    desc_t            head;

    logic             ram_we;
    logic [IDX_W:0]   ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W:0]   ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    // Configuration registers; an index beyond the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_reg <= OSC_W'(12000000);
            tgt_reg <= SPT_W'(875);
            tol_reg <= SPT_W'(50);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OSC_HZ:    osc_reg <= cfg_data;
                CFG_SP_TARGET: tgt_reg <= cfg_data[SPT_W-1:0];
                CFG_SP_TOL:    tol_reg <= cfg_data[SPT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.osc_hz    = osc_reg;
    assign cfg.sp_target = tgt_reg;
    assign cfg.sp_tol    = tol_reg;

    // Candidate search.
    can_bts_search #(
        .MAX_PRESCALER (MAX_PRESCALER),
        .MAX_SEG1      (MAX_SEG1),
        .MAX_SEG2      (MAX_SEG2),
        .MAX_MATCHES   (MAX_MATCHES),
        .IDX_W         (IDX_W),
        .RAM_W         (RAM_W)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_rate   (s_axis_tdata[RATE_W-1:0]),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // Two banks of stored matches.
    can_bts_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Finished searches waiting for the emitter.
    can_bts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Result formatting and output register.
    can_bts_emit #(
        .MAX_PRESCALER (MAX_PRESCALER),
        .MAX_SEG1      (MAX_SEG1),
        .MAX_SEG2      (MAX_SEG2),
        .IDX_W         (IDX_W),
        .RAM_W         (RAM_W)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .sp_target  (tgt_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

/* rtl/can_bts_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module can_bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/can_bts_queue.sv */
// Two-entry queue of finished search descriptors between search and emitter.
// Depends on can_bts_pkg.
module can_bts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  can_bts_pkg::desc_t  push_desc,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output can_bts_pkg::desc_t  head
);

    import can_bts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    desc_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [PTR_W:0]     count_reg;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

    assign full       = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rptr_reg];

endmodule

/* rtl/can_bts_search.sv */
// Front part: accepts a bit rate item and tests every prescaler and segment
// setting, one candidate per cycle, writing matches to a result bank.
// Depends on can_bts_pkg.
module can_bts_search #(
    parameter int MAX_PRESCALER = can_bts_pkg::DEF_MAX_PRESCALER,
    parameter int MAX_SEG1      = can_bts_pkg::DEF_MAX_SEG1,
    parameter int MAX_SEG2      = can_bts_pkg::DEF_MAX_SEG2,
    parameter int MAX_MATCHES   = can_bts_pkg::DEF_MAX_MATCHES,
    parameter int IDX_W         = 6,
    parameter int RAM_W         = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  can_bts_pkg::cfg_t                cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [can_bts_pkg::RATE_W-1:0]   in_rate,
    input  logic                             q_full,
    output logic                             push,
    output can_bts_pkg::desc_t               push_desc,
    output logic                             ram_we,
    output logic [IDX_W:0]                   ram_waddr,
    output logic [RAM_W-1:0]                 ram_wdata
);

    import can_bts_pkg::*;

    localparam int PW     = $clog2(MAX_PRESCALER + 1);
    localparam int S1W    = $clog2(MAX_SEG1 + 1);
    localparam int S2W    = $clog2(MAX_SEG2 + 1);
    localparam int NW     = $clog2(MAX_SEG1 + MAX_SEG2 + 2);
    localparam int CW     = $clog2(MAX_MATCHES + 1);
    localparam int PN_W   = PW + NW;
    localparam int PRAW_W = RATE_K_W + PN_W;
    localparam int PROD_W = (PRAW_W > OSC_W) ? PRAW_W : OSC_W;
    localparam int A_W    = $clog2(KILO * (MAX_SEG1 + 1) + 1);
    localparam int B_W    = SPT_W + NW;
    localparam int DEV_W  = (A_W > B_W) ? A_W : B_W;

    front_state_t state_reg, state_next;

    logic                 accept;
    logic                 run;
    logic                 last_cand;
    logic [RATE_K_W-1:0]  rate_k_reg;
    logic [PW-1:0]        brp_reg;
    logic [S1W-1:0]       s1_reg;
    logic [S2W-1:0]       s2_reg;
    logic [NW-1:0]        ntq0;

    // Stage one: bit length products.
    logic                 v1_reg;
    logic [PW-1:0]        brp1_reg;
    logic [S1W-1:0]       s1_1_reg;
    logic [S2W-1:0]       s2_1_reg;
    logic [PN_W-1:0]      pn1_reg;
    logic [B_W-1:0]       b1_reg;
    logic [B_W-1:0]       tn1_reg;
    logic [A_W-1:0]       a1_reg;
    logic [DEV_W-1:0]     dev1;

    // Stage two: clock product and sample point check.
    logic                 v2_reg;
    logic [PW-1:0]        brp2_reg;
    logic [S1W-1:0]       s1_2_reg;
    logic [S2W-1:0]       s2_2_reg;
    logic [PROD_W-1:0]    prod2_reg;
    logic                 ok2_reg;

    logic                 match;
    logic                 bank_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 trunc_reg;

    assign accept    = in_valid && in_ready;
    assign run       = (state_reg == F_RUN);
    assign last_cand = (brp_reg == PW'(MAX_PRESCALER)) && (s1_reg == S1W'(MAX_SEG1))
                       && (s2_reg == S2W'(MAX_SEG2));
    assign ntq0      = NW'(1) + NW'(s1_reg) + NW'(s2_reg);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = !q_full;
                if (in_valid && !q_full)
                begin
                    state_next = F_RUN;
                end
            end
            F_RUN:
            begin
                if (last_cand)
                begin
                    state_next = F_DRAIN;
                end
            end
            F_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Candidate counters, match count and bank select.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brp_reg   <= PW'(1);
            s1_reg    <= S1W'(1);
            s2_reg    <= S2W'(1);
            cnt_reg   <= '0;
            trunc_reg <= 1'b0;
            bank_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= run;
            v2_reg <= v1_reg;
            if (accept)
            begin
                brp_reg   <= PW'(1);
                s1_reg    <= S1W'(1);
                s2_reg    <= S2W'(1);
                cnt_reg   <= '0;
                trunc_reg <= 1'b0;
            end
            else if (run && !last_cand)
            begin
                if (s2_reg != S2W'(MAX_SEG2))
                begin
                    s2_reg <= s2_reg + 1'b1;
                end
                else
                begin
                    s2_reg <= S2W'(1);
                    if (s1_reg != S1W'(MAX_SEG1))
                    begin
                        s1_reg <= s1_reg + 1'b1;
                    end
                    else
                    begin
                        s1_reg  <= S1W'(1);
                        brp_reg <= brp_reg + 1'b1;
                    end
                end
            end
            if (match)
            begin
                if (cnt_reg < CW'(MAX_MATCHES))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    trunc_reg <= 1'b1;
                end
            end
            if (push)
            begin
                bank_reg <= !bank_reg;
            end
        end
    end

    // Scaled bit rate, taken once per item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rate_k_reg <= RATE_K_W'(in_rate) * RATE_K_W'(KILO);
        end
    end

    assign dev1 = (DEV_W'(a1_reg) >= DEV_W'(b1_reg)) ? (DEV_W'(a1_reg) - DEV_W'(b1_reg))
                                                     : (DEV_W'(b1_reg) - DEV_W'(a1_reg));

    // Candidate pipeline payload.
    always_ff @(posedge clk)
    begin
        brp1_reg  <= brp_reg;
        s1_1_reg  <= s1_reg;
        s2_1_reg  <= s2_reg;
        pn1_reg   <= PN_W'(brp_reg) * PN_W'(ntq0);
        b1_reg    <= B_W'(cfg.sp_target) * B_W'(ntq0);
        tn1_reg   <= B_W'(cfg.sp_tol) * B_W'(ntq0);
        a1_reg    <= A_W'(KILO) * (A_W'(s1_reg) + A_W'(1));

        brp2_reg  <= brp1_reg;
        s1_2_reg  <= s1_1_reg;
        s2_2_reg  <= s2_1_reg;
        prod2_reg <= PROD_W'(rate_k_reg) * PROD_W'(pn1_reg);
        ok2_reg   <= (dev1 < DEV_W'(tn1_reg));
    end

    // A candidate matches on an exact clock split and a close sample point.
    assign match     = v2_reg && ok2_reg && (prod2_reg == PROD_W'(cfg.osc_hz));
    assign ram_we    = match && (cnt_reg < CW'(MAX_MATCHES));
    assign ram_waddr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign ram_wdata = {brp2_reg, s1_2_reg, s2_2_reg};

    assign push_desc.bank      = bank_reg;
    assign push_desc.count     = CNT_W'(cnt_reg);
    assign push_desc.truncated = trunc_reg;

endmodule

/* rtl/can_bts_emit.sv */
// Back part: reads stored matches, works out sample point and error with a
// shared bit-serial divider and drives the registered result stream.
// Depends on can_bts_pkg.
module can_bts_emit #(
    parameter int MAX_PRESCALER = can_bts_pkg::DEF_MAX_PRESCALER,
    parameter int MAX_SEG1      = can_bts_pkg::DEF_MAX_SEG1,
    parameter int MAX_SEG2      = can_bts_pkg::DEF_MAX_SEG2,
    parameter int IDX_W         = 6,
    parameter int RAM_W         = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [can_bts_pkg::SPT_W-1:0]     sp_target,
    input  logic                              head_valid,
    input  can_bts_pkg::desc_t                head,
    output logic                              pop,
    output logic                              ram_re,
    output logic [IDX_W:0]                    ram_raddr,
    input  logic [RAM_W-1:0]                  ram_rdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [can_bts_pkg::M_TDATA_W-1:0] out_data,
    output logic [can_bts_pkg::M_TUSER_W-1:0] out_user,
    output logic                              out_last
);

    import can_bts_pkg::*;

    localparam int PW    = $clog2(MAX_PRESCALER + 1);
    localparam int S1W   = $clog2(MAX_SEG1 + 1);
    localparam int S2W   = $clog2(MAX_SEG2 + 1);
    localparam int NW    = $clog2(MAX_SEG1 + MAX_SEG2 + 2);
    localparam int A_W   = $clog2(KILO * (MAX_SEG1 + 1) + 1);
    localparam int B_W   = SPT_W + NW;
    localparam int DEV_W = (A_W > B_W) ? A_W : B_W;
    localparam int DD_W  = DEV_W + SCALE_W;
    localparam int DC_W  = $clog2(DD_W + 1);
    localparam int JW_CW = S2W + 2;

    back_state_t state_reg, state_next;

    logic                 out_free;
    logic                 out_load;
    logic                 is_last;
    logic                 nf_reg;
    logic [CNT_W-1:0]     idx_reg;

    logic [PW-1:0]        brp_rd;
    logic [S1W-1:0]       s1_rd;
    logic [S2W-1:0]       s2_rd;
    logic [NW-1:0]        ntq_rd;

    logic [PW-1:0]        brp_reg;
    logic [S1W-1:0]       s1_reg;
    logic [S2W-1:0]       s2_reg;
    logic [NW-1:0]        ntq_reg;
    logic [A_W-1:0]       a_reg;
    logic [B_W-1:0]       b_reg;
    logic [DEV_W-1:0]     dev_reg;
    logic [SP_W-1:0]      sp_reg;
    logic [ERR_W-1:0]     err_reg;

    // Restoring divider, one quotient bit per cycle.
    logic [DD_W-1:0]      div_q_reg;
    logic [B_W-1:0]       div_rem_reg;
    logic [B_W-1:0]       div_d_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic [B_W:0]         div_try;
    logic                 div_ge;
    logic [B_W-1:0]       div_rem_step;
    logic [DD_W-1:0]      div_q_step;
    logic                 div_last;

    logic [JW_CW-1:0]     jw_wide;
    logic [JW_W-1:0]      jw;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic                 m_last_reg;

    assign {brp_rd, s1_rd, s2_rd} = ram_rdata;
    assign ntq_rd = NW'(1) + NW'(s1_rd) + NW'(s2_rd);

    assign div_try      = {div_rem_reg, div_q_reg[DD_W-1]};
    assign div_ge       = (div_try >= {1'b0, div_d_reg});
    assign div_rem_step = div_ge ? B_W'(div_try - {1'b0, div_d_reg}) : div_try[B_W-1:0];
    assign div_q_step   = {div_q_reg[DD_W-2:0], div_ge};
    assign div_last     = (div_cnt_reg == DC_W'(1));

    assign out_free  = !m_valid_reg || out_ready;
    assign is_last   = nf_reg || ((idx_reg + CNT_W'(1)) == head.count);
    assign ram_raddr = {head.bank, idx_reg[IDX_W-1:0]};

    // State register and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            nf_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE)
            begin
                idx_reg <= '0;
                nf_reg  <= (head.count == '0);
            end
            else if (out_load && !is_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head.count == '0) ? B_SEND : B_READ;
                end
            end
            B_READ:
            begin
                ram_re     = 1'b1;
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                state_next = B_DIV_SP;
            end
            B_DIV_SP:
            begin
                if (div_last)
                begin
                    state_next = (b_reg == '0) ? B_SEND : B_DIV_ERR;
                end
            end
            B_DIV_ERR:
            begin
                if (div_last)
                begin
                    state_next = B_SEND;
                end
            end
            B_SEND:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Match fields, error terms and divider.
    always_ff @(posedge clk)
    begin
        b_reg   <= B_W'(sp_target) * B_W'(ntq_reg);
        dev_reg <= (DEV_W'(a_reg) >= DEV_W'(b_reg)) ? (DEV_W'(a_reg) - DEV_W'(b_reg))
                                                    : (DEV_W'(b_reg) - DEV_W'(a_reg));
        unique case (state_reg)
            B_LOAD:
            begin
                brp_reg     <= brp_rd;
                s1_reg      <= s1_rd;
                s2_reg      <= s2_rd;
                ntq_reg     <= ntq_rd;
                a_reg       <= A_W'(KILO) * (A_W'(s1_rd) + A_W'(1));
                div_q_reg   <= DD_W'(SP_SCALE) * (DD_W'(s1_rd) + DD_W'(1));
                div_rem_reg <= '0;
                div_d_reg   <= B_W'(ntq_rd);
                div_cnt_reg <= DC_W'(DD_W);
            end
            B_DIV_SP:
            begin
                if (div_last)
                begin
                    // Sample point done; start the relative error division.
                    sp_reg      <= div_q_step[SP_W-1:0];
                    err_reg     <= ERR_W'(ERR_MAX);
                    div_q_reg   <= DD_W'(dev_reg) * DD_W'(SP_SCALE);
                    div_rem_reg <= '0;
                    div_d_reg   <= b_reg;
                    div_cnt_reg <= DC_W'(DD_W);
                end
                else
                begin
                    div_q_reg   <= div_q_step;
                    div_rem_reg <= div_rem_step;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
            end
            B_DIV_ERR:
            begin
                div_q_reg   <= div_q_step;
                div_rem_reg <= div_rem_step;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_last)
                begin
                    // Saturate a large relative error.
                    err_reg <= (div_q_step > DD_W'(ERR_MAX)) ? ERR_W'(ERR_MAX)
                                                             : div_q_step[ERR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Resync jump width is segment two less one, at most three.
    assign jw_wide = JW_CW'(s2_reg) - JW_CW'(1);
    assign jw      = (jw_wide > JW_CW'(JW_MAX)) ? JW_W'(JW_MAX) : jw_wide[JW_W-1:0];

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload; a not-found item carries only the last mark.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_last_reg <= is_last;
            if (nf_reg)
            begin
                m_data_reg <= '0;
                m_user_reg <= '0;
            end
            else
            begin
                m_data_reg <= {{M_PAD_W{1'b0}}, head.truncated, err_reg, sp_reg, jw,
                               SEG2_OUT_W'(s2_reg), SEG1_OUT_W'(s1_reg),
                               PRESC_OUT_W'(brp_reg)};
                m_user_reg <= M_TUSER_W'(1);
            end
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
    assign out_user  = m_user_reg;
    assign out_last  = m_last_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Stream-level testbench for the CAN bit timing search unit: one rate per item
// goes in, matching settings come out, each checked against an in-bench search.
// Depends on can_bts_pkg and the RTL of can_bit_timing_search_unit.
module testbench;
    import can_bts_pkg::*;

    localparam int IDLE_PCT      = 32;
    localparam int HOLD_CYCLES   = 16000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 18;
    localparam int MIN_NTQ       = 3;
    localparam int MAX_NTQ       = 1 + DEF_MAX_SEG1 + DEF_MAX_SEG2;
    localparam int MAX_RATE      = (1 << RATE_W) - 1;

    localparam logic [OSC_W-1:0] OSC_RESET = 28'd12000000;
    localparam logic [SPT_W-1:0] SPT_RESET = 10'd875;
    localparam logic [SPT_W-1:0] TOL_RESET = 10'd50;
    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // One result item, unpacked.
    typedef struct packed {
        logic                   found;
        logic [PRESC_OUT_W-1:0] prescaler;
        logic [SEG1_OUT_W-1:0]  seg1;
        logic [SEG2_OUT_W-1:0]  seg2;
        logic [JW_W-1:0]        jump_width;
        logic [SP_W-1:0]        sample_point;
        logic [ERR_W-1:0]       sample_error;
        logic                   truncated;
        logic                   last;
    } bit_timing_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [OSC_W-1:0]       cfg_data = '0;

    // Bench copy of the register set, used by the search below.
    logic [OSC_W-1:0] osc_setting = OSC_RESET;
    logic [SPT_W-1:0] sp_target_setting = SPT_RESET;
    logic [SPT_W-1:0] sp_tol_setting = TOL_RESET;

    logic [RATE_W-1:0] pending_rates[$];
    logic [RATE_W-1:0] good_rates[$];
    bit_timing_t       timing_expected[$];

    int queued_count = 0;
    int accepted_count = 0;
    int fail_count = 0;
    int hold_trigger = 0;
    int hold_seen;
    int hold_left;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    can_bit_timing_search_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Exhaustive search over all settings for one rate; queues the results it implies.
    function automatic void predict_timings(input logic [RATE_W-1:0] rate);
        bit_timing_t       hits[$];
        bit_timing_t       entry;
        longint unsigned   ntq, a, b, dev, err, total, osc_l, rate_l, tgt_l, tol_l;
        total  = 0;
        osc_l  = 64'(osc_setting);
        rate_l = 64'(rate);
        tgt_l  = 64'(sp_target_setting);
        tol_l  = 64'(sp_tol_setting);
        for (int brp = 1; brp <= DEF_MAX_PRESCALER; brp++)
        begin
            for (int s1 = 1; s1 <= DEF_MAX_SEG1; s1++)
            begin
                for (int s2 = 1; s2 <= DEF_MAX_SEG2; s2++)
                begin
                    ntq = 64'(1 + s1 + s2);
                    if (osc_l != rate_l * KILO * longint'(brp) * ntq)
                        continue;
                    a = 64'(KILO * (1 + s1));
                    b = tgt_l * ntq;
                    dev = (a >= b) ? (a - b) : (b - a);
                    if (dev >= tol_l * ntq)
                        continue;
                    total++;
                    if (hits.size() >= DEF_MAX_MATCHES)
                        continue;
                    // A zero target makes the relative error unbounded.
                    if (b == 0)
                        err = 64'(ERR_MAX);
                    else
                        err = (dev * SP_SCALE) / b;
                    if (err > ERR_MAX)
                        err = 64'(ERR_MAX);
                    entry = '0;
                    entry.found        = 1'b1;
                    entry.prescaler    = PRESC_OUT_W'(brp);
                    entry.seg1         = SEG1_OUT_W'(s1);
                    entry.seg2         = SEG2_OUT_W'(s2);
                    entry.jump_width   = JW_W'((s2 - 1 < JW_MAX) ? s2 - 1 : JW_MAX);
                    entry.sample_point = SP_W'((SP_SCALE * (1 + s1)) / ntq);
                    entry.sample_error = ERR_W'(err);
                    hits = {hits, entry};
                end
            end
        end
        // Nothing matched: a single result, zero but for its last mark, that closes the request.
        if (hits.size() == 0)
        begin
            entry = '0;
            entry.last = 1'b1;
            timing_expected = {timing_expected, entry};
        end
        else
        begin
            foreach (hits[i])
            begin
                hits[i].truncated = (total > DEF_MAX_MATCHES);
                hits[i].last      = (i == hits.size() - 1);
                timing_expected = {timing_expected, hits[i]};
            end
        end
    endfunction

    // Rates for which the current clock divides into some prescaler and bit length.
    function automatic void collect_good_rates();
        longint unsigned q;
        good_rates.delete();
        for (int r = 1; r <= MAX_RATE; r++)
        begin
            if (longint'(osc_setting) % (KILO * r) != 0)
                continue;
            q = longint'(osc_setting) / (KILO * r);
            for (int brp = 1; brp <= DEF_MAX_PRESCALER; brp++)
            begin
                if (q % brp == 0 && q / brp >= MIN_NTQ && q / brp <= MAX_NTQ)
                begin
                    good_rates = {good_rates, RATE_W'(r)};
                    break;
                end
            end
        end
    endfunction

    // One register write over the configuration channel.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [OSC_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_OSC_HZ)
            osc_setting = val;
        else if (idx == CFG_SP_TARGET)
            sp_target_setting = val[SPT_W-1:0];
        else if (idx == CFG_SP_TOL)
            sp_tol_setting = val[SPT_W-1:0];
    endtask

    task automatic apply_settings(input logic [OSC_W-1:0] osc, input logic [SPT_W-1:0] tgt,
                                  input logic [SPT_W-1:0] tol);
        write_reg(CFG_OSC_HZ, osc);
        write_reg(CFG_SP_TARGET, tgt);
        write_reg(CFG_SP_TOL, tol);
        @(negedge clk);
    endtask

    task automatic offer_rate(input logic [RATE_W-1:0] rate);
        pending_rates = {pending_rates, rate};
        queued_count++;
    endtask

    // Mostly rates that can match the current clock, the rest anywhere in the field.
    task automatic random_batch(input int count);
        collect_good_rates();
        for (int i = 0; i < count; i++)
        begin
            if (good_rates.size() != 0 && $urandom_range(99, 0) < 75)
                offer_rate(good_rates[$urandom_range(good_rates.size() - 1, 0)]);
            else
                offer_rate(RATE_W'($urandom_range(MAX_RATE, 0)));
        end
    endtask

    // Wait until every offered item is in and every result is out.
    task automatic settle();
        @(negedge clk);
        while (accepted_count != queued_count || timing_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: presents queued rates, predicts on each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_timings(s_axis_tdata[RATE_W-1:0]);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_rates.size() != 0 && (tx_calm || $urandom_range(99, 0) >= IDLE_PCT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(S_TDATA_W - RATE_W){1'b0}}, pending_rates.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started whenever the sequence bumps the trigger.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: random ready, each accepted result checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        bit_timing_t got;
        bit_timing_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.prescaler    = m_axis_tdata[5:0];
                got.seg1         = m_axis_tdata[10:6];
                got.seg2         = m_axis_tdata[14:11];
                got.jump_width   = m_axis_tdata[16:15];
                got.sample_point = m_axis_tdata[30:17];
                got.sample_error = m_axis_tdata[44:31];
                got.truncated    = m_axis_tdata[45];
                got.found        = m_axis_tuser[0];
                got.last         = m_axis_tlast;
                if (timing_expected.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result: found=%0d presc=%0d seg1=%0d seg2=%0d",
                                 $realtime, got.found, got.prescaler, got.seg1, got.seg2);
                end
                else
                begin
                    want = timing_expected.pop_front();
                    if (got.found !== want.found || got.prescaler !== want.prescaler
                        || got.seg1 !== want.seg1 || got.seg2 !== want.seg2
                        || got.jump_width !== want.jump_width
                        || got.sample_point !== want.sample_point
                        || got.sample_error !== want.sample_error
                        || got.truncated !== want.truncated || got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("[%0t] mismatch (found presc seg1 seg2 sjw sp err trunc last)",
                                     $realtime);
                            $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                                     want.found, want.prescaler, want.seg1, want.seg2,
                                     want.jump_width, want.sample_point, want.sample_error,
                                     want.truncated, want.last);
                            $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                                     got.found, got.prescaler, got.seg1, got.seg2,
                                     got.jump_width, got.sample_point, got.sample_error,
                                     got.truncated, got.last);
                        end
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && (rx_calm || $urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    // Run limit.
    initial
    begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Sequence: directed settings and rates, then random phases.
    initial
    begin
        logic [OSC_W-1:0] osc_pick;
        logic [SPT_W-1:0] tgt_pick;
        logic [SPT_W-1:0] tol_pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: common rates, the field extremes and a zero rate.
        offer_rate(10'd500);
        offer_rate(10'd250);
        offer_rate(10'd125);
        offer_rate(10'd1000);
        offer_rate(10'd100);
        offer_rate(10'd1023);
        offer_rate(10'd0);
        offer_rate(10'd1);
        offer_rate(10'd512);
        settle();

        // Zero clock: a zero rate matches every candidate and truncates.
        apply_settings(28'd0, 10'd875, 10'd1000);
        offer_rate(10'd0);
        offer_rate(10'd1);
        settle();

        // Zero target sample point gives the saturated error.
        apply_settings(28'd16000000, 10'd0, 10'd1023);
        offer_rate(10'd500);
        offer_rate(10'd1000);
        settle();

        // Tiny target with wide tolerance: large relative errors saturate.
        apply_settings(28'd8000000, 10'd1, 10'd1000);
        offer_rate(10'd250);
        offer_rate(10'd125);
        settle();

        // All-ones clock, maximum target, zero tolerance; a write to a spare index.
        apply_settings(28'hFFFFFFF, 10'd1023, 10'd0);
        write_reg(CFG_UNUSED, 28'hFFFFFFF);
        @(negedge clk);
        offer_rate(10'd1023);
        offer_rate(10'd341);
        settle();

        // Highest nominal clock with the widest tolerance.
        apply_settings(28'd200000000, 10'd875, 10'd1023);
        offer_rate(10'd1000);
        offer_rate(10'd500);
        settle();

        // Random phases; in one neither side idles, in another the sender does not idle and the receiver is held off.
        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(11, 0))
                0:       osc_pick = 28'd1;
                1:       osc_pick = 28'd8000000;
                2:       osc_pick = 28'd12000000;
                3:       osc_pick = 28'd16000000;
                4:       osc_pick = 28'd20000000;
                5:       osc_pick = 28'd24000000;
                6:       osc_pick = 28'd32000000;
                7:       osc_pick = 28'd40000000;
                8:       osc_pick = 28'd48000000;
                9:       osc_pick = 28'd80000000;
                10:      osc_pick = 28'd200000000;
                default: osc_pick = OSC_W'($urandom_range(200000000, 1));
            endcase
            if ($urandom_range(99, 0) < 70)
                tgt_pick = SPT_W'($urandom_range(950, 500));
            else
                tgt_pick = SPT_W'($urandom_range(1023, 0));
            case ($urandom_range(6, 0))
                0:       tol_pick = 10'd0;
                1:       tol_pick = 10'd20;
                2:       tol_pick = 10'd50;
                3:       tol_pick = 10'd100;
                4:       tol_pick = 10'd250;
                5:       tol_pick = 10'd1023;
                default: tol_pick = SPT_W'($urandom_range(1023, 0));
            endcase
            apply_settings(osc_pick, tgt_pick, tol_pick);
            tx_calm = (p == 2) || (p == 4);
            rx_calm = (p == 2);
            random_batch(PHASE_ITEMS);
            if (p == 4)
                hold_trigger++;
            settle();
            tx_calm = 1'b0;
            rx_calm = 1'b0;
        end

        repeat (100) @(negedge clk);
        if (fail_count == 0 && timing_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
rtl/can_bts_pkg.sv
rtl/can_bts_ram.sv
rtl/can_bts_queue.sv
rtl/can_bts_search.sv
rtl/can_bts_emit.sv
rtl/can_bit_timing_search_unit.sv
dv/testbench.sv
